// File: rtl/adm_pkg.sv
package adm_pkg;

	// expo curve table
	localparam int EXPO_TABLE_DEPTH = 1024;
	localparam int EXPO_HUNDREDTHS  = 105;
	localparam int EXPO_IDX_W       = $clog2(EXPO_TABLE_DEPTH);

	// fixed point: 1.0 is 2^16
	localparam int          Q16_W   = 17;
	localparam logic [16:0] Q16_ONE = 17'h10000;

	// pipeline sizes
	localparam int DB_STEPS   = 16;
	localparam int NORM_STEPS = 17;
	localparam int LR_W       = 20;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEADBAND       = 3'd0,
		REG_STEER_GAIN     = 3'd1,
		REG_BASE_STEER     = 3'd2,
		REG_SPIN_GAIN      = 3'd3,
		REG_SPIN_THRESHOLD = 3'd4
	} cfg_reg_t;

	localparam logic [14:0] DEADBAND_RST       = 15'd1966;
	localparam logic [16:0] STEER_GAIN_RST     = 17'd45875;
	localparam logic [16:0] BASE_STEER_RST     = 17'd13107;
	localparam logic [16:0] SPIN_GAIN_RST      = 17'd58982;
	localparam logic [16:0] SPIN_THRESHOLD_RST = 17'd3277;

	typedef logic [Q16_W-1:0] expo_rom_t [EXPO_TABLE_DEPTH];

	// integer square root, bit by bit
	function automatic logic [63:0] isqrt(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = 64'd0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > v) b = b >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 64'd0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
		end
		return r;
	endfunction

	// log2 in Q24
	function automatic logic [63:0] log2_fixed(input logic [63:0] n);
		logic [63:0] y;
		logic [63:0] res;
		int p;
		p = 0;
		for (int i = 0; i < 63; i++) begin
			if ((n >> (p + 1)) != 64'd0) p++;
		end
		y = (n << 30) >> p;
		res = 64'(p) << 24;
		for (int k = 23; k >= 0; k--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				res = res | (64'd1 << k);
			end
		end
		return res;
	endfunction

	// (i/depth)^(hundredths/100) in Q16, rounded half up
	function automatic expo_rom_t build_expo_rom();
		expo_rom_t rom;
		logic [63:0] roots [24];
		logic [63:0] root;
		logic [63:0] log_depth;
		logic [63:0] li;
		logic [63:0] lmag;
		logic [63:0] tmag;
		logic [63:0] ip;
		logic [63:0] fr;
		logic [63:0] g;
		logic [63:0] r;
		logic [63:0] val;
		root = 64'd1 << 31;
		for (int k = 0; k < 24; k++) begin
			root = isqrt(root << 30);
			roots[k] = root;
		end
		log_depth = log2_fixed(64'(EXPO_TABLE_DEPTH));
		rom[0] = '0;
		for (int i = 1; i < EXPO_TABLE_DEPTH; i++) begin
			li   = log2_fixed(64'(i));
			lmag = (li > log_depth) ? 64'd0 : log_depth - li;
			tmag = (lmag * 64'(EXPO_HUNDREDTHS)) / 64'd100;
			ip   = tmag >> 24;
			fr   = tmag & ((64'd1 << 24) - 64'd1);
			if (fr == 64'd0) begin
				val = (ip < 64'd63) ? ((64'd1 << 30) >> ip) : 64'd0;
			end else begin
				g = (64'd1 << 24) - fr;
				r = 64'd1 << 30;
				for (int k = 0; k < 24; k++) begin
					if (g[23-k]) r = (r * roots[k]) >> 30;
				end
				val = (ip + 64'd1 < 64'd63) ? (r >> (ip + 64'd1)) : 64'd0;
			end
			rom[i] = Q16_W'((val + (64'd1 << 13)) >> 14);
		end
		return rom;
	endfunction

endpackage

// File: rtl/adm_if.sv
interface adm_in_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] throttle_stick;
	logic signed [7:0] turn_stick;
	modport source(output valid, throttle_stick, turn_stick, input ready);
	modport sink(input valid, throttle_stick, turn_stick, output ready);
endinterface

interface adm_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] left_drive;
	logic signed [7:0] right_drive;
	modport source(output valid, left_drive, right_drive, input ready);
	modport sink(input valid, left_drive, right_drive, output ready);
endinterface

interface adm_cfg_if import adm_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/adm_axis_shaper.sv
module adm_axis_shaper import adm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic signed [7:0]  stick,
	input  logic [14:0]        deadband,
	output logic               out_valid,
	output logic signed [17:0] value
);

	localparam expo_rom_t EXPO_ROM = build_expo_rom();

	logic [7:0]  kmag;
	logic [9:0]  k4;
	logic [2:0]  frac;
	logic [16:0] mag;
	logic [16:0] db_ext;
	logic [16:0] dif;
	logic [16:0] divisor;

	logic [16:0] rem_s  [DB_STEPS+1];
	logic [16:0] dvs_s  [DB_STEPS+1];
	logic [15:0] quo_s  [DB_STEPS+1];
	logic        neg_s  [DB_STEPS+1];
	logic        zero_s [DB_STEPS+1];
	logic        sat_s  [DB_STEPS+1];
	logic        vld_s  [DB_STEPS+1];

	logic [Q16_W-1:0] rom_data_s17;
	logic             neg_s17;
	logic             zero_s17;
	logic             sat_s17;
	logic             vld_s17;
	logic [16:0]      mag_out;

	// scale to q16: 516*k plus floor(4k/127)
	always_comb begin
		kmag    = stick[7] ? 8'(-stick) : 8'(stick);
		k4      = {kmag, 2'b00};
		frac    = 3'(k4 >= 10'd127) + 3'(k4 >= 10'd254) + 3'(k4 >= 10'd381)
			+ 3'(k4 >= 10'd508);
		mag     = 17'(kmag) * 17'd516 + 17'(frac);
		db_ext  = {2'b00, deadband};
		dif     = mag - db_ext;
		divisor = Q16_ONE - db_ext;
	end

	// deadband setup stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= dif;
			dvs_s[0]  <= divisor;
			quo_s[0]  <= '0;
			neg_s[0]  <= stick[7];
			zero_s[0] <= (mag <= db_ext);
			sat_s[0]  <= (dif >= divisor);
		end
	end

	// rescale divider, one quotient bit per stage
	for (genvar j = 0; j < DB_STEPS; j++) begin : g_db
		logic [17:0] trial;
		logic        take;
		assign trial = {rem_s[j], 1'b0};
		assign take  = trial >= {1'b0, dvs_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? 17'(trial - {1'b0, dvs_s[j]}) : trial[16:0];
				dvs_s[j+1]  <= dvs_s[j];
				quo_s[j+1]  <= {quo_s[j][14:0], take};
				neg_s[j+1]  <= neg_s[j];
				zero_s[j+1] <= zero_s[j];
				sat_s[j+1]  <= sat_s[j];
			end
		end
	end

	// expo table lookup, registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s17 <= 1'b0;
		end else if (en) begin
			vld_s17 <= vld_s[DB_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rom_data_s17 <= EXPO_ROM[quo_s[DB_STEPS][15 -: EXPO_IDX_W]];
			neg_s17      <= neg_s[DB_STEPS];
			zero_s17     <= zero_s[DB_STEPS];
			sat_s17      <= sat_s[DB_STEPS];
		end
	end

	// inside deadband gives zero, full scale saturates
	assign mag_out   = zero_s17 ? '0 : (sat_s17 ? Q16_ONE : rom_data_s17);
	assign value     = neg_s17 ? -$signed({1'b0, mag_out}) : $signed({1'b0, mag_out});
	assign out_valid = vld_s17;

endmodule

// File: rtl/arcade_drive_mixer.sv
// throughput: one request per cycle; the pipeline advances as one unit and holds
//   while the output register is full and not taken
// the rescale divider (16 stages) and normalize divider (17 stages) set the depth
// reset: pipeline emptied, config registers back to their defaults
module arcade_drive_mixer import adm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	adm_cfg_if.sink   cfg,
	adm_in_if.sink    sticks,
	adm_out_if.source drive
);

	logic [14:0] deadband_q;
	logic [16:0] steer_gain_q;
	logic [16:0] base_steer_q;
	logic [16:0] spin_gain_q;
	logic [16:0] spin_threshold_q;

	logic en;
	logic out_vld_q;
	logic signed [7:0] out_left_q;
	logic signed [7:0] out_right_q;

	logic               t_vld;
	logic               r_vld;
	logic signed [17:0] t_val;
	logic signed [17:0] r_val;
	logic [16:0]        t_mag;
	logic [16:0]        r_mag;

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q       <= DEADBAND_RST;
			steer_gain_q     <= STEER_GAIN_RST;
			base_steer_q     <= BASE_STEER_RST;
			spin_gain_q      <= SPIN_GAIN_RST;
			spin_threshold_q <= SPIN_THRESHOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DEADBAND:       deadband_q       <= cfg.data[14:0];
				REG_STEER_GAIN:     steer_gain_q     <= cfg.data;
				REG_BASE_STEER:     base_steer_q     <= cfg.data;
				REG_SPIN_GAIN:      spin_gain_q      <= cfg.data;
				REG_SPIN_THRESHOLD: spin_threshold_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the output holds an untaken result
	assign en           = !out_vld_q || drive.ready;
	assign sticks.ready = en;

	adm_axis_shaper u_throttle (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sticks.valid),
		.stick     (sticks.throttle_stick),
		.deadband  (deadband_q),
		.out_valid (t_vld),
		.value     (t_val)
	);

	adm_axis_shaper u_turn (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sticks.valid),
		.stick     (sticks.turn_stick),
		.deadband  (deadband_q),
		.out_valid (r_vld),
		.value     (r_val)
	);

	assign t_mag = t_val[17] ? 17'(-t_val) : t_val[16:0];
	assign r_mag = r_val[17] ? 17'(-r_val) : r_val[16:0];

	// stage 1: spin decision and throttle-scaled steering gain product
	logic               vld_s1;
	logic signed [17:0] t_s1;
	logic [16:0]        rmag_s1;
	logic               rneg_s1;
	logic               spin_s1;
	logic [33:0]        prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= t_vld & r_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_val;
			rmag_s1 <= r_mag;
			rneg_s1 <= r_val[17];
			spin_s1 <= t_mag < spin_threshold_q;
			prod_s1 <= 34'(steer_gain_q) * 34'(t_mag);
		end
	end

	// stage 2: turn gain
	logic               vld_s2;
	logic signed [17:0] t_s2;
	logic [16:0]        rmag_s2;
	logic               rneg_s2;
	logic               spin_s2;
	logic [18:0]        gain_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2    <= t_s1;
			rmag_s2 <= rmag_s1;
			rneg_s2 <= rneg_s1;
			spin_s2 <= spin_s1;
			gain_s2 <= spin_s1 ? 19'(spin_gain_q)
				: 19'(prod_s1[33:16]) + 19'(base_steer_q);
		end
	end

	// stage 3: turn times gain
	logic               vld_s3;
	logic signed [17:0] t_s3;
	logic               rneg_s3;
	logic               spin_s3;
	logic [35:0]        prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3    <= t_s2;
			rneg_s3 <= rneg_s2;
			spin_s3 <= spin_s2;
			prod_s3 <= 36'(rmag_s2) * 36'(gain_s2);
		end
	end

	// stage 4: mix into left and right
	logic                   vld_s4;
	logic signed [LR_W-1:0] left_s4;
	logic signed [LR_W-1:0] right_s4;
	logic signed [LR_W-1:0] a_val;
	logic signed [LR_W-1:0] t_ext;

	always_comb begin
		a_val = rneg_s3 ? -$signed(prod_s3[35:16]) : $signed(prod_s3[35:16]);
		t_ext = LR_W'(t_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_s4  <= spin_s3 ? a_val : t_ext + a_val;
			right_s4 <= spin_s3 ? -a_val : t_ext - a_val;
		end
	end

	// stage 5 onward: normalize by the larger magnitude
	logic [LR_W-2:0] lmag;
	logic [LR_W-2:0] rmag;
	logic [LR_W-2:0] peak;

	logic [LR_W-2:0]  lrem_s [NORM_STEPS+1];
	logic [LR_W-2:0]  rrem_s [NORM_STEPS+1];
	logic [LR_W-2:0]  lmag_s [NORM_STEPS+1];
	logic [LR_W-2:0]  rmag_s [NORM_STEPS+1];
	logic [LR_W-2:0]  peak_s [NORM_STEPS+1];
	logic [Q16_W-1:0] lquo_s [NORM_STEPS+1];
	logic [Q16_W-1:0] rquo_s [NORM_STEPS+1];
	logic             lneg_s [NORM_STEPS+1];
	logic             rneg_s [NORM_STEPS+1];
	logic             norm_s [NORM_STEPS+1];
	logic             nvld_s [NORM_STEPS+1];

	always_comb begin
		lmag = left_s4[LR_W-1] ? (LR_W-1)'(-left_s4) : left_s4[LR_W-2:0];
		rmag = right_s4[LR_W-1] ? (LR_W-1)'(-right_s4) : right_s4[LR_W-2:0];
		peak = (lmag > rmag) ? lmag : rmag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nvld_s[0] <= 1'b0;
		end else if (en) begin
			nvld_s[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lrem_s[0] <= lmag;
			rrem_s[0] <= rmag;
			lmag_s[0] <= lmag;
			rmag_s[0] <= rmag;
			peak_s[0] <= peak;
			lquo_s[0] <= '0;
			rquo_s[0] <= '0;
			lneg_s[0] <= left_s4[LR_W-1];
			rneg_s[0] <= right_s4[LR_W-1];
			norm_s[0] <= peak > (LR_W-1)'(Q16_ONE);
		end
	end

	// two divider lanes; the first step yields the integer bit
	for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
		logic [LR_W-1:0] ltrial;
		logic [LR_W-1:0] rtrial;
		logic            ltake;
		logic            rtake;

		if (j == 0) begin : g_first
			assign ltrial = {1'b0, lrem_s[j]};
			assign rtrial = {1'b0, rrem_s[j]};
		end else begin : g_next
			assign ltrial = {lrem_s[j], 1'b0};
			assign rtrial = {rrem_s[j], 1'b0};
		end
		assign ltake = ltrial >= {1'b0, peak_s[j]};
		assign rtake = rtrial >= {1'b0, peak_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				nvld_s[j+1] <= 1'b0;
			end else if (en) begin
				nvld_s[j+1] <= nvld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				lrem_s[j+1] <= ltake ? (LR_W-1)'(ltrial - {1'b0, peak_s[j]})
					: ltrial[LR_W-2:0];
				rrem_s[j+1] <= rtake ? (LR_W-1)'(rtrial - {1'b0, peak_s[j]})
					: rtrial[LR_W-2:0];
				lquo_s[j+1] <= {lquo_s[j][Q16_W-2:0], ltake};
				rquo_s[j+1] <= {rquo_s[j][Q16_W-2:0], rtake};
				lmag_s[j+1] <= lmag_s[j];
				rmag_s[j+1] <= rmag_s[j];
				peak_s[j+1] <= peak_s[j];
				lneg_s[j+1] <= lneg_s[j];
				rneg_s[j+1] <= rneg_s[j];
				norm_s[j+1] <= norm_s[j];
			end
		end
	end

	// motor command: value times 127, truncated toward zero
	logic [Q16_W-1:0] lval;
	logic [Q16_W-1:0] rval;
	logic [23:0]      lcmd;
	logic [23:0]      rcmd;

	always_comb begin
		lval = norm_s[NORM_STEPS] ? lquo_s[NORM_STEPS] : Q16_W'(lmag_s[NORM_STEPS]);
		rval = norm_s[NORM_STEPS] ? rquo_s[NORM_STEPS] : Q16_W'(rmag_s[NORM_STEPS]);
		lcmd = 24'(lval) * 24'd127;
		rcmd = 24'(rval) * 24'd127;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= nvld_s[NORM_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_left_q  <= lneg_s[NORM_STEPS] ? -$signed({1'b0, lcmd[22:16]})
				: $signed({1'b0, lcmd[22:16]});
			out_right_q <= rneg_s[NORM_STEPS] ? -$signed({1'b0, rcmd[22:16]})
				: $signed({1'b0, rcmd[22:16]});
		end
	end

	assign drive.valid       = out_vld_q;
	assign drive.left_drive  = out_left_q;
	assign drive.right_drive = out_right_q;

	// both axis shapers stay in lockstep
	a_axes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		t_vld == r_vld)
		else $error("axis shapers out of step");

	// normalized sides never exceed full scale
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		nvld_s[NORM_STEPS] && norm_s[NORM_STEPS] |->
		lquo_s[NORM_STEPS] <= Q16_ONE && rquo_s[NORM_STEPS] <= Q16_ONE)
		else $error("normalize quotient above full scale");

	// commands stay within plus or minus 127
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive.valid |-> drive.left_drive != 8'sh80 && drive.right_drive != 8'sh80)
		else $error("motor command out of range");

endmodule

// File: tb/sv/adm_scoreboard.sv
module adm_scoreboard import adm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	adm_cfg_if   cfg,
	adm_in_if    sticks,
	adm_out_if   drive,
	output int   pending,
	output int   errors
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [7:0] left;
		logic signed [7:0] right;
	} motor_pair_t;

	motor_pair_t motor_q [$];
	logic [16:0] curve [EXPO_TABLE_DEPTH];

	logic [14:0] deadband_q;
	logic [16:0] steer_full_q;
	logic [16:0] base_steer_q;
	logic [16:0] spin_gain_q;
	logic [16:0] spin_thresh_q;

	// floor of the square root, digit by digit
	function automatic longint unsigned sqrt_floor(longint unsigned v);
		longint unsigned acc;
		longint unsigned rem;
		longint unsigned b;
		acc = 0;
		rem = v;
		b = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= acc + b) begin
				rem = rem - (acc + b);
				acc = (acc >> 1) + b;
			end else begin
				acc = acc >> 1;
			end
			b = b >> 2;
		end
		return acc;
	endfunction

	// base-2 logarithm with 24 fraction bits
	function automatic longint unsigned log2_q24(longint unsigned n);
		int unsigned msb;
		longint unsigned y;
		longint unsigned acc;
		msb = 0;
		while ((n >> (msb + 1)) != 0) msb++;
		y = (n << 30) >> msb;
		acc = longint'(msb) << 24;
		for (int k = 23; k >= 0; k--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y = y >> 1;
				acc = acc | (64'd1 << k);
			end
		end
		return acc;
	endfunction

	// expo curve values, same integer recipe as the hardware table
	initial begin
		longint unsigned halves [24];
		longint unsigned x, ld, lm, tm, whole, frac, acc, v;
		x = 64'd1 << 31;
		for (int k = 0; k < 24; k++) begin
			x = sqrt_floor(x << 30);
			halves[k] = x;
		end
		ld = log2_q24(EXPO_TABLE_DEPTH);
		curve[0] = '0;
		for (int i = 1; i < EXPO_TABLE_DEPTH; i++) begin
			lm = log2_q24(i);
			lm = (lm > ld) ? 0 : ld - lm;
			tm = (lm * EXPO_HUNDREDTHS) / 100;
			whole = tm >> 24;
			frac = tm & ((64'd1 << 24) - 1);
			if (frac == 0) begin
				v = (whole < 63) ? ((64'd1 << 30) >> whole) : 0;
			end else begin
				acc = 64'd1 << 30;
				for (int k = 0; k < 24; k++)
					if ((((64'd1 << 24) - frac) >> (23 - k)) & 1) acc = (acc * halves[k]) >> 30;
				v = (whole + 1 < 63) ? (acc >> (whole + 1)) : 0;
			end
			curve[i] = 17'((v + (64'd1 << 13)) >> 14);
		end
	end

	function automatic longint labs(longint x);
		return (x < 0) ? -x : x;
	endfunction

	// stick to shaped Q16 axis: scale, deadband rescale, expo
	function automatic longint shape_stick(logic signed [7:0] stick);
		longint s, m, db;
		s = (longint'(stick) * 65536) / 127;
		m = labs(s);
		db = longint'(deadband_q);
		if (m <= db) return 0;
		m = ((m - db) * 65536) / (65536 - db);
		if (m >= 65536) m = 65536;
		else m = longint'(curve[(m * EXPO_TABLE_DEPTH) >> 16]);
		return (s < 0) ? -m : m;
	endfunction

	function automatic logic signed [7:0] motor_cmd(longint v);
		if (v > 65536) v = 65536;
		if (v < -65536) v = -65536;
		return 8'((v * 127) / 65536);
	endfunction

	function automatic motor_pair_t mix_sticks(logic signed [7:0] thr, logic signed [7:0] trn);
		longint t, r, lft, rgt, a, g, peak;
		motor_pair_t p;
		t = shape_stick(thr);
		r = shape_stick(trn);
		if (labs(t) < longint'(spin_thresh_q)) begin
			a = (r * longint'(spin_gain_q)) / 65536;
			lft = a;
			rgt = -a;
		end else begin
			g = (longint'(steer_full_q) * labs(t)) / 65536 + longint'(base_steer_q);
			a = (r * g) / 65536;
			lft = t + a;
			rgt = t - a;
		end
		peak = (labs(lft) > labs(rgt)) ? labs(lft) : labs(rgt);
		if (peak > 65536) begin
			lft = (lft * 65536) / peak;
			rgt = (rgt * 65536) / peak;
		end
		p.left = motor_cmd(lft);
		p.right = motor_cmd(rgt);
		return p;
	endfunction

	// register shadow
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RST;
			steer_full_q <= STEER_GAIN_RST;
			base_steer_q <= BASE_STEER_RST;
			spin_gain_q <= SPIN_GAIN_RST;
			spin_thresh_q <= SPIN_THRESHOLD_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_DEADBAND:       deadband_q <= cfg.data[14:0];
				REG_STEER_GAIN:     steer_full_q <= cfg.data;
				REG_BASE_STEER:     base_steer_q <= cfg.data;
				REG_SPIN_GAIN:      spin_gain_q <= cfg.data;
				REG_SPIN_THRESHOLD: spin_thresh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	initial begin
		errors = 0;
		pending = 0;
	end

	// predict on each request, compare each motor command pair
	always @(posedge clk) begin
		motor_pair_t want;
		if (arst_n) begin
			if (sticks.valid && sticks.ready)
				motor_q.push_back(mix_sticks(sticks.throttle_stick, sticks.turn_stick));
			if (drive.valid && drive.ready) begin
				if (motor_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected drive output l=%0d r=%0d",
							drive.left_drive, drive.right_drive);
				end else begin
					want = motor_q.pop_front();
					if (want.left !== drive.left_drive || want.right !== drive.right_drive) begin
						errors++;
						if (errors <= 10)
							$display("drive mismatch: exp l=%0d r=%0d got l=%0d r=%0d",
								want.left, want.right, drive.left_drive, drive.right_drive);
					end
				end
			end
		end
		pending = motor_q.size();
	end
endmodule

// File: tb/sv/tb_arcade_drive_mixer.sv
module tb_arcade_drive_mixer import adm_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic quiet;
	int   pending;
	int   errors;
	int   idle_cycles;

	adm_cfg_if cfg();
	adm_in_if  sticks();
	adm_out_if drive();

	arcade_drive_mixer i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg.sink),
		.sticks(sticks.sink),
		.drive(drive.source)
	);

	adm_scoreboard i_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.sticks(sticks),
		.drive(drive),
		.pending(pending),
		.errors(errors)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// output back-pressure in bursts
	int stall_left;
	initial stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			drive.ready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 16);
			drive.ready <= 1'b0;
		end else begin
			drive.ready <= 1'b1;
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((sticks.valid && sticks.ready) || (drive.valid && drive.ready) ||
			(cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one request; valid stays high across back-to-back requests
	task automatic send_sticks(logic signed [7:0] thr, logic signed [7:0] trn);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			sticks.valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		sticks.valid <= 1'b1;
		sticks.throttle_stick <= thr;
		sticks.turn_stick <= trn;
		do @(posedge clk); while (!sticks.ready);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [16:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	task automatic drain();
		sticks.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic load_regs(logic [16:0] db, logic [16:0] sf, logic [16:0] bs,
		logic [16:0] sg, logic [16:0] st);
		write_reg(REG_DEADBAND, db);
		write_reg(REG_STEER_GAIN, sf);
		write_reg(REG_BASE_STEER, bs);
		write_reg(REG_SPIN_GAIN, sg);
		write_reg(REG_SPIN_THRESHOLD, st);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_stick();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(0, 10) - 5);
			1: return $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
			2: return 8'($urandom_range(0, 16) - 8);
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic random_run(int n);
		for (int k = 0; k < n; k++) send_sticks(rand_stick(), rand_stick());
	endtask

	logic signed [7:0] directed [20][2] = '{
		'{0, 0}, '{127, 127}, '{-127, -127}, '{-128, -128}, '{127, -128},
		'{-128, 127}, '{0, 127}, '{0, -127}, '{127, 0}, '{-127, 0},
		'{2, 100}, '{-3, -90}, '{4, 0}, '{1, 1}, '{-1, -1},
		'{100, 50}, '{-60, 90}, '{10, -10}, '{6, 127}, '{-128, 0}
	};

	initial begin
		quiet = 1'b0;
		idle_cycles = 0;
		cfg.valid = 1'b0;
		cfg.index = REG_DEADBAND;
		cfg.data = '0;
		sticks.valid = 1'b0;
		sticks.throttle_stick = '0;
		sticks.turn_stick = '0;
		drive.ready = 1'b1;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at reset settings
		foreach (directed[i]) send_sticks(directed[i][0], directed[i][1]);
		random_run(200);
		drain();

		// all gains zero, no deadband
		load_regs(17'd0, 17'd0, 17'd0, 17'd0, 17'd0);
		foreach (directed[i]) send_sticks(directed[i][0], directed[i][1]);
		random_run(150);
		drain();

		// top of stated ranges
		load_regs(17'd32767, 17'd65536, 17'd65536, 17'd65536, 17'd65536);
		random_run(150);
		drain();

		// all bits set, beyond stated range
		load_regs(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h1FFFF);
		random_run(150);
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			load_regs(17'($urandom_range(0, 8000)), 17'($urandom_range(0, 65536)),
				17'($urandom_range(0, 65536)), 17'($urandom_range(0, 65536)),
				17'($urandom_range(0, 20000)));
			random_run(180);
			drain();
		end

		// last stretch at full rate
		load_regs(17'd1966, 17'd45875, 17'd13107, 17'd58982, 17'd3277);
		quiet = 1'b1;
		random_run(120);
		drain();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
